FILE: hdl/bb3_pkg.sv
// Shared constants, types and codes for the 3x3 RGB box blur.
package bb3_pkg;

    localparam int MAX_WIDTH_DEF = 1024;
    localparam int HEIGHT_LIMIT  = 4096;
    localparam int WIDTH_RESET   = 640;
    localparam int HEIGHT_RESET  = 480;

    localparam int CHAN_W      = 8;
    localparam int PIX_W       = 3 * CHAN_W;
    localparam int ROW_W       = 13;
    localparam int CFG_WIDTH_W = 11;
    localparam int CFG_DATA_W  = 13;
    localparam int CFG_INDEX_W = 1;
    localparam int SUM_W       = 12;
    localparam int CNT_W       = 4;
    localparam int NUM_W       = 13;
    localparam int DEN_W       = 5;
    localparam int STEP_W      = 3;

    typedef logic [CHAN_W-1:0] chan_t;
    typedef logic [PIX_W-1:0] pixel_t;
    typedef logic [2:0][SUM_W-1:0] sums_t;
    typedef logic [2:0][CHAN_W-1:0] means_t;

    typedef enum logic {
        KIND_PIXEL = 1'b0,
        KIND_DRAIN = 1'b1
    } kind_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_IMAGE_WIDTH  = 1'b0,
        CFG_IMAGE_HEIGHT = 1'b1
    } cfg_index_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_SUM,
        ST_DIV
    } state_t;

    typedef struct packed {
        logic up_ok;
        logic down_ok;
        logic left_ok;
        logic right_ok;
    } edge_mask_t;

endpackage

FILE: hdl/bb3_pix_if.sv
// Input pixel/drain stream channel.
interface bb3_pix_if;
    import bb3_pkg::*;

    logic  valid;
    logic  ready;
    logic  kind;
    chan_t red_in;
    chan_t green_in;
    chan_t blue_in;

    modport source (output valid, output kind, output red_in, output green_in,
                    output blue_in, input ready);
    modport sink (input valid, input kind, input red_in, input green_in,
                  input blue_in, output ready);
endinterface

FILE: hdl/bb3_res_if.sv
// Output blurred pixel stream channel.
interface bb3_res_if;
    import bb3_pkg::*;

    logic  valid;
    logic  ready;
    chan_t red_out;
    chan_t green_out;
    chan_t blue_out;
    logic  frame_end;

    modport source (output valid, output red_out, output green_out, output blue_out,
                    output frame_end, input ready);
    modport sink (input valid, input red_out, input green_out, input blue_out,
                  input frame_end, output ready);
endinterface

FILE: hdl/bb3_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module bb3_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 1024,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [0:DEPTH-1];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: hdl/bb3_window.sv
// 3x3 pixel window with edge-masked per-channel sums and neighbor count.
module bb3_window (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  shift_en,
    input  bb3_pkg::pixel_t       col_top,
    input  bb3_pkg::pixel_t       col_mid,
    input  bb3_pkg::pixel_t       col_bot,
    input  bb3_pkg::edge_mask_t   mask,
    output bb3_pkg::sums_t        sums,
    output logic [bb3_pkg::CNT_W-1:0] count
);
    import bb3_pkg::*;

    // [row][col], col 2 is the newest column
    pixel_t win_reg [0:2][0:2];
    logic [2:0] row_ok;
    logic [2:0] col_ok;

    assign row_ok = {mask.down_ok, 1'b1, mask.up_ok};
    assign col_ok = {mask.right_ok, 1'b1, mask.left_ok};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < 3; r++)
            begin
                for (int c = 0; c < 3; c++)
                begin
                    win_reg[r][c] <= '0;
                end
            end
        end
        else if (shift_en)
        begin
            for (int r = 0; r < 3; r++)
            begin
                win_reg[r][0] <= win_reg[r][1];
                win_reg[r][1] <= win_reg[r][2];
            end
            win_reg[0][2] <= col_top;
            win_reg[1][2] <= col_mid;
            win_reg[2][2] <= col_bot;
        end
    end

    always_comb
    begin
        sums  = '0;
        count = '0;
        for (int r = 0; r < 3; r++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                if (row_ok[r] && col_ok[c])
                begin
                    count = count + CNT_W'(1);
                    for (int ch = 0; ch < 3; ch++)
                    begin
                        sums[ch] = sums[ch] + SUM_W'(win_reg[r][c][ch*CHAN_W +: CHAN_W]);
                    end
                end
            end
        end
    end

endmodule

FILE: hdl/bb3_div.sv
// Three-lane restoring divider: floor((2*sum + n) / (2*n)), one quotient bit per cycle.
module bb3_div (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  bb3_pkg::sums_t            sums,
    input  logic [bb3_pkg::CNT_W-1:0] count,
    output bb3_pkg::means_t           quot,
    output logic                      done
);
    import bb3_pkg::*;

    logic [2:0][NUM_W-1:0] rem_reg, rem_next;
    means_t                quot_reg, quot_next;
    logic [DEN_W-1:0]      den_reg, den_next;
    logic [STEP_W-1:0]     step_reg, step_next;
    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [NUM_W-1:0]      trial;

    assign quot = quot_reg;
    assign done = done_reg;

    always_comb
    begin
        rem_next  = rem_reg;
        quot_next = quot_reg;
        den_next  = den_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = done_reg;
        trial     = NUM_W'(den_reg) << step_reg;
        if (start)
        begin
            for (int i = 0; i < 3; i++)
            begin
                rem_next[i] = NUM_W'({sums[i], 1'b0}) + NUM_W'(count);
            end
            quot_next = '0;
            den_next  = {count, 1'b0};
            step_next = '1;
            busy_next = 1'b1;
            done_next = 1'b0;
        end
        else if (busy_reg)
        begin
            for (int i = 0; i < 3; i++)
            begin
                if (rem_reg[i] >= trial)
                begin
                    rem_next[i]            = rem_reg[i] - trial;
                    quot_next[i][step_reg] = 1'b1;
                end
            end
            step_next = step_reg - STEP_W'(1);
            if (step_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        quot_reg <= quot_next;
        den_reg  <= den_next;
    end

endmodule

FILE: hdl/box_blur_3x3_rgb.sv
// 3x3 RGB box blur over a raster pixel stream. Each output pixel is the per-channel
// mean of its in-frame 3x3 neighbors (9, 6 or 4 of them, fewer on one-pixel-wide or
// one-row frames), rounded half up. Results trail the input by one row plus one pixel;
// after the last pixel of a frame, drain transactions (kind = 1) push out the pending
// results, the last one flagged with frame_end. A pixel arriving after the frame's last
// pixel starts a new frame. Two line stores (above and current row) share one RAM word
// per column, read and rewritten once per pixel. An input transaction that yields a result
// occupies the block until the 8-step shared divider is done and the output register can
// take it (the first drain of a one-row frame steps past column 0 first); a pixel that
// yields none returns to idle after its READ state, an ignored drain never leaves idle. A
// new transaction is accepted while a finished result still waits in the output register.
// Writing image_width or image_height restarts the frame; write them only while idle.
// Reset values: 640 x 480. No clearing pass is needed after reset.
module box_blur_3x3_rgb #(
    parameter int MAX_WIDTH = bb3_pkg::MAX_WIDTH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [bb3_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [bb3_pkg::CFG_DATA_W-1:0]  cfg_data,
    bb3_pix_if.sink                         pix,
    bb3_res_if.source                       res
);
    import bb3_pkg::*;

    localparam int ADDR_W     = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int COL_W      = $clog2(MAX_WIDTH + 2);
    localparam int WIDTH_INIT = (WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH : WIDTH_RESET;

    state_t             state_reg, state_next;
    logic [COL_W-1:0]   col_reg, col_next, width_reg, width_next;
    logic [COL_W-1:0]   col_plus, ccol;
    logic [ROW_W-1:0]   row_reg, row_next, height_reg, height_next, crow;
    logic               done_reg, done_next;
    logic               kind_reg;
    pixel_t             px_reg;
    edge_mask_t         mask_reg, mask_next;
    logic               fend_reg;
    logic [CFG_WIDTH_W-1:0] cfg_w;
    logic [ROW_W-1:0]   cfg_h;

    logic               pix_fire, restart, drain_go, in_range, at_col0, emit, fend;

    logic               ram_we, ram_re;
    logic [ADDR_W-1:0]  ram_waddr, ram_raddr;
    logic [2*PIX_W-1:0] ram_wdata, ram_rdata;

    logic               win_shift;
    pixel_t             new_top, new_mid, new_bot;
    sums_t              win_sums;
    logic [CNT_W-1:0]   win_count;

    logic               div_start, div_done;
    means_t             div_quot;

    logic               out_valid_reg, out_valid_next;
    means_t             out_data_reg;
    logic               out_fend_reg;
    logic               out_free, out_load;

    // Line stores: upper half = row above, lower half = current row
    bb3_ram #(
        .WIDTH (2 * PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    bb3_window u_window (
        .clk      (clk),
        .rst_n    (rst_n),
        .shift_en (win_shift),
        .col_top  (new_top),
        .col_mid  (new_mid),
        .col_bot  (new_bot),
        .mask     (mask_reg),
        .sums     (win_sums),
        .count    (win_count)
    );

    bb3_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .sums  (win_sums),
        .count (win_count),
        .quot  (div_quot),
        .done  (div_done)
    );

    assign pix.ready     = (state_reg == ST_IDLE);
    assign pix_fire      = pix.valid && pix.ready;
    assign restart       = (row_reg >= height_reg);
    assign drain_go      = restart && !done_reg;
    assign in_range      = (col_reg < width_reg);
    assign at_col0       = (col_reg == '0);
    assign col_plus      = col_reg + COL_W'(1);

    // Center of the result produced by this column step
    assign crow = at_col0 ? row_reg - ROW_W'(2) : row_reg - ROW_W'(1);
    assign ccol = at_col0 ? width_reg - COL_W'(1) : col_reg - COL_W'(1);
    assign emit = at_col0 ? (row_reg >= ROW_W'(2)) : (row_reg >= ROW_W'(1));
    assign fend = (crow == height_reg - ROW_W'(1)) && (ccol == width_reg - COL_W'(1));

    assign mask_next.up_ok    = (crow != '0);
    assign mask_next.down_ok  = ((crow + ROW_W'(1)) < height_reg);
    assign mask_next.left_ok  = (ccol != '0);
    assign mask_next.right_ok = ((ccol + COL_W'(1)) < width_reg);

    assign new_top   = in_range ? ram_rdata[2*PIX_W-1:PIX_W] : '0;
    assign new_mid   = in_range ? ram_rdata[PIX_W-1:0] : '0;
    assign new_bot   = (kind_reg == KIND_PIXEL) ? px_reg : '0;
    assign ram_wdata = {new_mid, px_reg};
    assign ram_waddr = col_reg[ADDR_W-1:0];

    assign out_free  = !out_valid_reg || res.ready;

    assign cfg_w = cfg_data[CFG_WIDTH_W-1:0];
    assign cfg_h = cfg_data[ROW_W-1:0];

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (pix_fire && (pix.kind == KIND_PIXEL || drain_go))
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                if (emit)
                begin
                    state_next = ST_SUM;
                end
                else if (kind_reg == KIND_DRAIN && col_plus <= width_reg)
                begin
                    state_next = ST_READ;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_SUM:
            begin
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_done && out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs of the sequencer. The line store entry is written in the READ cycle and
    // the next transaction's read is issued no earlier than the following cycle.
    always_comb
    begin
        ram_re    = 1'b0;
        ram_raddr = col_plus[ADDR_W-1:0];
        ram_we    = 1'b0;
        win_shift = 1'b0;
        div_start = 1'b0;
        out_load  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                ram_re    = pix_fire;
                ram_raddr = (pix.kind == KIND_PIXEL && restart) ? '0 : col_reg[ADDR_W-1:0];
            end
            ST_READ:
            begin
                win_shift = 1'b1;
                ram_we    = (kind_reg == KIND_PIXEL) && in_range;
                ram_re    = (kind_reg == KIND_DRAIN) && !emit;
                ram_raddr = col_plus[ADDR_W-1:0];
            end
            ST_SUM:
            begin
                div_start = 1'b1;
            end
            ST_DIV:
            begin
                out_load = div_done && out_free;
            end
            default:
            begin
                ram_re = 1'b0;
            end
        endcase
    end

    // Frame counters and configuration
    always_comb
    begin
        col_next    = col_reg;
        row_next    = row_reg;
        done_next   = done_reg;
        width_next  = width_reg;
        height_next = height_reg;

        if (state_reg == ST_IDLE && pix_fire && pix.kind == KIND_PIXEL && restart)
        begin
            col_next  = '0;
            row_next  = '0;
            done_next = 1'b0;
        end
        else if (state_reg == ST_READ)
        begin
            if (kind_reg == KIND_PIXEL)
            begin
                if (col_plus >= width_reg)
                begin
                    col_next = '0;
                    row_next = row_reg + ROW_W'(1);
                end
                else
                begin
                    col_next = col_plus;
                end
            end
            else
            begin
                col_next = col_plus;
                if ((emit && fend) || col_plus > width_reg)
                begin
                    done_next = 1'b1;
                end
            end
        end

        if (cfg_we)
        begin
            case (cfg_index)
                CFG_IMAGE_WIDTH:
                begin
                    if (cfg_w == '0)
                    begin
                        width_next = COL_W'(1);
                    end
                    else if (32'(cfg_w) > 32'(MAX_WIDTH))
                    begin
                        width_next = COL_W'(MAX_WIDTH);
                    end
                    else
                    begin
                        width_next = COL_W'(cfg_w);
                    end
                    col_next  = '0;
                    row_next  = '0;
                    done_next = 1'b0;
                end
                CFG_IMAGE_HEIGHT:
                begin
                    if (cfg_h == '0)
                    begin
                        height_next = ROW_W'(1);
                    end
                    else if (32'(cfg_h) > 32'(HEIGHT_LIMIT))
                    begin
                        height_next = ROW_W'(HEIGHT_LIMIT);
                    end
                    else
                    begin
                        height_next = cfg_h;
                    end
                    col_next  = '0;
                    row_next  = '0;
                    done_next = 1'b0;
                end
                default:
                begin
                    done_next = done_reg;
                end
            endcase
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (res.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            col_reg       <= '0;
            row_reg       <= '0;
            done_reg      <= 1'b0;
            width_reg     <= COL_W'(WIDTH_INIT);
            height_reg    <= ROW_W'(HEIGHT_RESET);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            done_reg      <= done_next;
            width_reg     <= width_next;
            height_reg    <= height_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pix_fire)
        begin
            kind_reg <= pix.kind;
            px_reg   <= {pix.red_in, pix.green_in, pix.blue_in};
        end
        if (state_reg == ST_READ)
        begin
            mask_reg <= mask_next;
            fend_reg <= fend;
        end
        if (out_load)
        begin
            out_data_reg <= div_quot;
            out_fend_reg <= fend_reg;
        end
    end

    assign res.valid     = out_valid_reg;
    assign res.red_out   = out_data_reg[2];
    assign res.green_out = out_data_reg[1];
    assign res.blue_out  = out_data_reg[0];
    assign res.frame_end = out_fend_reg;

`ifndef SYNTH
    a_col_bound: assert property (@(posedge clk) disable iff (!rst_n)
        col_reg <= width_reg + COL_W'(1))
        else $error("column counter ran past the drain limit");

    a_fend_in_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_READ && emit && fend) |-> kind_reg == KIND_DRAIN)
        else $error("frame end result produced outside a drain");

    a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SUM) |-> win_count != '0)
        else $error("divider started with an empty neighborhood");

    a_load_after_div: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res.valid) |-> $past(state_reg == ST_DIV && div_done))
        else $error("result presented without a finished division");
`endif

endmodule

FILE: test/tb_box_blur_3x3_rgb.sv
// Self-checking testbench for the 3x3 RGB box blur: scoreboard class plus handshake drivers.
`timescale 1ns / 1ps

module tb_box_blur_3x3_rgb;
    import bb3_pkg::*;

    localparam int STYLE_MIXED   = 0;
    localparam int STYLE_CHECKER = 1;
    localparam int STYLE_FULL    = 2;

    typedef struct packed {
        chan_t red;
        chan_t green;
        chan_t blue;
        logic  frame_end;
    } blur_px_t;

    // Tracks the frame geometry, line buffers and 3x3 window, and queues the
    // blurred pixels each accepted transaction should produce.
    class blur_tracker;
        int       cols;
        int       rows;
        pixel_t   upper_line [MAX_WIDTH_DEF];
        pixel_t   lower_line [MAX_WIDTH_DEF];
        pixel_t   win [9];
        int       in_col;
        int       in_row;
        bit       frame_closed;
        blur_px_t expected [$];
        int       checked;
        int       mismatches;
        int       frames_ended;

        function new();
            cols = WIDTH_RESET;
            rows = HEIGHT_RESET;
            foreach (upper_line[i])
            begin
                upper_line[i] = '0;
                lower_line[i] = '0;
            end
            foreach (win[i])
                win[i] = '0;
            checked = 0;
            mismatches = 0;
            frames_ended = 0;
            restart();
        endfunction

        function void restart();
            in_col = 0;
            in_row = 0;
            frame_closed = 1'b0;
        endfunction

        function void set_reg(cfg_index_t idx, logic [CFG_DATA_W-1:0] data);
            int v;
            if (idx == CFG_IMAGE_WIDTH)
            begin
                v = int'(data[CFG_WIDTH_W-1:0]);
                cols = (v == 0) ? 1 : (v > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : v;
            end
            else
            begin
                v = int'(data);
                rows = (v == 0) ? 1 : (v > HEIGHT_LIMIT) ? HEIGHT_LIMIT : v;
            end
            restart();
        endfunction

        function void slide(int col, pixel_t px, bit keep);
            pixel_t top;
            pixel_t mid;
            int     r;
            top = '0;
            mid = '0;
            if (col < cols && col < MAX_WIDTH_DEF)
            begin
                top = upper_line[col];
                mid = lower_line[col];
                if (keep)
                begin
                    upper_line[col] = mid;
                    lower_line[col] = px;
                end
            end
            for (r = 0; r < 3; r++)
            begin
                win[r * 3]     = win[r * 3 + 1];
                win[r * 3 + 1] = win[r * 3 + 2];
            end
            win[2] = top;
            win[5] = mid;
            win[8] = px;
        endfunction

        // wc: window column holding the center pixel
        function blur_px_t window_mean(int crow, int ccol, int wc);
            int       sum [3];
            int       cnt;
            int       rr;
            int       cc;
            int       j;
            int       dr;
            int       dc;
            int       ch;
            int       v;
            pixel_t   p;
            blur_px_t m;
            cnt = 0;
            for (ch = 0; ch < 3; ch++)
                sum[ch] = 0;
            for (dr = -1; dr <= 1; dr++)
            begin
                for (dc = -1; dc <= 1; dc++)
                begin
                    rr = crow + dr;
                    cc = ccol + dc;
                    j  = wc + dc;
                    if (rr >= 0 && rr < rows && cc >= 0 && cc < cols && j >= 0 && j <= 2)
                    begin
                        p = win[(dr + 1) * 3 + j];
                        sum[0] += p[23:16];
                        sum[1] += p[15:8];
                        sum[2] += p[7:0];
                        cnt++;
                    end
                end
            end
            for (ch = 0; ch < 3; ch++)
            begin
                v = (cnt == 0) ? 0 : (2 * sum[ch] + cnt) / (2 * cnt);
                sum[ch] = (v > 255) ? 255 : v;
            end
            m.red       = chan_t'(sum[0]);
            m.green     = chan_t'(sum[1]);
            m.blue      = chan_t'(sum[2]);
            m.frame_end = (crow == rows - 1 && ccol == cols - 1);
            return m;
        endfunction

        // Column k of input row r; r equals rows while draining.
        function bit step_column(int k, int r, pixel_t px, bit keep, output blur_px_t res);
            bit got;
            got = 1'b0;
            res = '0;
            // column 0 finishes the right-edge pixel two rows up
            if (k == 0 && r >= 2)
            begin
                res = window_mean(r - 2, cols - 1, 2);
                got = 1'b1;
            end
            slide(k, px, keep);
            if (k >= 1 && r >= 1)
            begin
                res = window_mean(r - 1, k - 1, 1);
                got = 1'b1;
            end
            return got;
        endfunction

        function bit note_input(kind_t k, pixel_t px);
            blur_px_t res;
            bit       got;
            got = 1'b0;
            if (k == KIND_PIXEL)
            begin
                if (in_row >= rows)
                    restart();
                got = step_column(in_col, in_row, px, 1'b1, res);
                in_col++;
                if (in_col >= cols)
                begin
                    in_col = 0;
                    in_row++;
                end
            end
            else if (in_row >= rows && !frame_closed)
            begin
                // walk trailing columns until one yields a pixel
                while (!got && !frame_closed && in_col <= cols)
                begin
                    got = step_column(in_col, rows, '0, 1'b0, res);
                    in_col++;
                    if (got && res.frame_end)
                        frame_closed = 1'b1;
                end
                if (in_col > cols)
                    frame_closed = 1'b1;
            end
            if (got)
                expected.push_back(res);
            return got;
        endfunction

        function void compare_field(string field, int want, int seen);
            if (want != seen)
            begin
                $error("%s mismatch: expected %0d, got %0d", field, want, seen);
                mismatches++;
            end
        endfunction

        function void check(blur_px_t seen);
            blur_px_t want;
            if (expected.size() == 0)
            begin
                $error("unexpected result r=%0d g=%0d b=%0d frame_end=%0d",
                       seen.red, seen.green, seen.blue, seen.frame_end);
                mismatches++;
                return;
            end
            want = expected.pop_front();
            checked++;
            if (seen.frame_end)
                frames_ended++;
            compare_field("red_out", want.red, seen.red);
            compare_field("green_out", want.green, seen.green);
            compare_field("blue_out", want.blue, seen.blue);
            compare_field("frame_end", want.frame_end, seen.frame_end);
        endfunction
    endclass

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    bb3_pix_if pix_ch ();
    bb3_res_if res_ch ();

    box_blur_3x3_rgb dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pix       (pix_ch),
        .res       (res_ch)
    );

    blur_tracker tracker;
    int          live_items;
    int          sent_items;
    int          settings_used;
    bit          steady;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #10_000_000;
        $display("timeout: stimulus or results stopped moving");
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic pixel_t pixel_for(int style, int idx);
        int pick;
        if (style == STYLE_FULL)
            return '1;
        if (style == STYLE_CHECKER)
            return idx[0] ? '1 : '0;
        pick = $urandom_range(99);
        if (pick < 10)
            return '1;
        if (pick < 20)
            return '0;
        return pixel_t'($urandom);
    endfunction

    // Offer one transaction, with random gaps ahead of it, and hold until accepted.
    task automatic push_item(kind_t k, pixel_t px);
        bit yielded;
        while (!steady && $urandom_range(99) < 31)
        begin
            pix_ch.valid <= 1'b0;
            @(posedge clk);
        end
        pix_ch.valid    <= 1'b1;
        pix_ch.kind     <= k;
        pix_ch.red_in   <= px[23:16];
        pix_ch.green_in <= px[15:8];
        pix_ch.blue_in  <= px[7:0];
        @(posedge clk);
        while (!pix_ch.ready)
            @(posedge clk);
        yielded = tracker.note_input(k, px);
        if (k == KIND_PIXEL || yielded)
            live_items++;
        sent_items++;
    endtask

    task automatic feed_pixels(int n, int style);
        int i;
        for (i = 0; i < n; i++)
            push_item(KIND_PIXEL, pixel_for(style, i));
    endtask

    task automatic feed_drains(int n);
        int i;
        for (i = 0; i < n; i++)
            push_item(KIND_DRAIN, pixel_t'($urandom));
    endtask

    // Stop offering, let every result out, then cover the block's own latency.
    task automatic wait_for_quiet();
        pix_ch.valid <= 1'b0;
        @(posedge clk);
        while (tracker.expected.size() != 0)
            @(posedge clk);
        repeat (24) @(posedge clk);
    endtask

    task automatic write_regs(logic [CFG_DATA_W-1:0] wdata, logic [CFG_DATA_W-1:0] hdata);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_IMAGE_WIDTH;
        cfg_data  <= wdata;
        tracker.set_reg(CFG_IMAGE_WIDTH, wdata);
        @(posedge clk);
        cfg_index <= CFG_IMAGE_HEIGHT;
        cfg_data  <= hdata;
        tracker.set_reg(CFG_IMAGE_HEIGHT, hdata);
        @(posedge clk);
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    initial
    begin : result_sink
        blur_px_t seen;
        int       stall_left;
        bit       stall_used;
        stall_left = 0;
        stall_used = 1'b0;
        res_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (res_ch.valid && res_ch.ready)
            begin
                seen.red       = res_ch.red_out;
                seen.green     = res_ch.green_out;
                seen.blue      = res_ch.blue_out;
                seen.frame_end = res_ch.frame_end;
                tracker.check(seen);
            end
            if (stall_left > 0)
            begin
                stall_left--;
                res_ch.ready <= 1'b0;
            end
            else if (!stall_used && pix_ch.valid && tracker.checked >= 60)
            begin
                // long hold-off so the block backs up into its input side
                stall_used = 1'b1;
                stall_left = 299;
                res_ch.ready <= 1'b0;
            end
            else
                res_ch.ready <= steady || ($urandom_range(99) >= 31);
        end
    end

    initial
    begin : stimulus
        int                    w;
        int                    h;
        int                    sel;
        int                    nfr;
        int                    f;
        int                    mode;
        int                    area;
        int                    lim;
        int                    n;
        int                    cut;
        int                    style;
        int                    phase;
        logic [CFG_DATA_W-1:0] wdata;
        logic [CFG_DATA_W-1:0] hdata;

        tracker = new();
        live_items    = 0;
        sent_items    = 0;
        settings_used = 0;
        steady        = 1'b0;
        phase         = 0;

        rst_n           <= 1'b0;
        cfg_we          <= 1'b0;
        cfg_index       <= CFG_IMAGE_WIDTH;
        cfg_data        <= '0;
        pix_ch.valid    <= 1'b0;
        pix_ch.kind     <= KIND_PIXEL;
        pix_ch.red_in   <= '0;
        pix_ch.green_in <= '0;
        pix_ch.blue_in  <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // drain before any pixel of the reset-size frame: ignored
        push_item(KIND_DRAIN, '1);
        wait_for_quiet();

        // zero width and height act as one: single-pixel frame, extra drain ignored
        write_regs('0, '0);
        push_item(KIND_PIXEL, '1);
        feed_drains(2);
        wait_for_quiet();

        // 3x2 with a stray drain mid-frame; checker pattern exercises rounding
        write_regs(13'd3, 13'd2);
        feed_pixels(2, STYLE_CHECKER);
        push_item(KIND_DRAIN, '1);
        feed_pixels(4, STYLE_CHECKER);
        feed_drains(5);
        wait_for_quiet();

        // pixel after the last pixel opens a new frame, dropping what is pending
        write_regs(13'd2, 13'd2);
        feed_pixels(4, STYLE_FULL);
        feed_drains(1);
        feed_pixels(4, STYLE_MIXED);
        feed_drains(3);

        while (live_items < 700)
        begin
            sel = $urandom_range(99);
            if (sel < 65)
                w = $urandom_range(1, 8);
            else if (sel < 88)
                w = $urandom_range(9, 40);
            else if (sel < 94)
                w = 0;
            else
                w = $urandom_range(MAX_WIDTH_DEF + 1, 2047);
            sel = $urandom_range(99);
            if (sel < 70)
                h = $urandom_range(1, 6);
            else if (sel < 85)
                h = $urandom_range(7, 12);
            else if (sel < 93)
                h = 0;
            else
                h = $urandom_range(HEIGHT_LIMIT, 8191);
            // bits above the width field are don't-care and get random values
            wdata = {2'($urandom_range(0, 3)), 11'(w)};
            hdata = 13'(h);

            wait_for_quiet();
            write_regs(wdata, hdata);
            steady = (phase >= 3 && phase <= 5);
            nfr = $urandom_range(1, 3);
            for (f = 0; f < nfr; f++)
            begin
                mode = $urandom_range(99);
                sel = $urandom_range(99);
                style = (sel < 75) ? STYLE_MIXED : (sel < 90) ? STYLE_CHECKER : STYLE_FULL;
                area = tracker.cols * tracker.rows;
                if (area > 1 && (area > 160 || mode >= 88))
                begin
                    // broken frame: partial pixels with a stray drain among them
                    lim = (area - 1 < 96) ? area - 1 : 96;
                    n = $urandom_range(1, lim);
                    cut = $urandom_range(0, n);
                    feed_pixels(cut, style);
                    push_item(KIND_DRAIN, pixel_t'($urandom));
                    feed_pixels(n - cut, style);
                    break;
                end
                feed_pixels(area, style);
                if (mode < 12)
                    feed_drains($urandom_range(0, tracker.cols - 1));
                else
                begin
                    while (!tracker.frame_closed)
                        push_item(KIND_DRAIN, pixel_t'($urandom));
                    feed_drains($urandom_range(0, 2));
                end
            end
            steady = 1'b0;
            phase++;
        end

        // widest and tallest settings clamp to the limits; a few pixels of the first row
        wait_for_quiet();
        write_regs(13'h07FF, 13'h1FFF);
        feed_pixels(8, STYLE_MIXED);

        wait_for_quiet();
        $display("Run covered %0d input transactions over %0d register settings,",
                 sent_items, settings_used);
        $display("checking %0d blurred pixels and %0d frame ends.",
                 tracker.checked, tracker.frames_ended);
        if (tracker.mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
